[design/rsakd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsakd_pkg
// Shared constants and controller/datapath interface types for the toy RSA
// key derivation block.
// ----------------------------------------------------------------------------
package rsakd_pkg;

  // Default width of each prime factor
  localparam int PRIME_BITS_DEF = 15;
  // Result field widths
  localparam int MOD_BITS = 30;
  localparam int EXP_BITS = 5;
  // Internal exponent width: the smallest exponent coprime with any totient
  // up to 62 bits stays well below 128
  localparam int EXP_W = 7;
  // First exponent candidate
  localparam logic [EXP_W-1:0] E_FIRST = EXP_W'(2);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // latch factors, clear private exponent and failure flag
    logic mul_n;     // modulus = p * q
    logic mul_phi;   // totient = (p-1)(q-1), restart exponent search
    logic div_init;  // start totient / exponent
    logic div_step;  // one quotient bit
    logic gcd_init;  // gcd operands = exponent, remainder
    logic gcd_step;  // one subtract-or-swap step
    logic e_inc;     // next exponent candidate
    logic fail_set;  // flag failure
    logic d_init;    // first private exponent term
    logic d_step;    // next private exponent term
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_last;  // last quotient bit in progress
    logic gcd_done;  // second gcd operand is zero
    logic gcd_one;   // first gcd operand is one
    logic e_lt_phi;  // exponent below totient
    logic d_hit;     // numerator divisible by exponent
  } dp_stat_t;

endpackage

[design/rsa_small_key_derivation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_small_key_derivation
// Toy RSA key set from two prime factors: modulus, public and private
// exponent, with a failure flag when no usable exponent exists.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_prime_p / in_prime_q and pulse start; the beat is
//   taken at an edge where start is high and busy is low. busy rises at that
//   same edge and stays high until the result is out.
//   Result channel: out_valid is high for exactly one cycle with out_modulus,
//   out_public_exp, out_private_exp and out_failed. The receiver cannot
//   stall; sample the result in that cycle (ports hold until the next start).
//   Sequence from the accepting edge: setup (modulus, then totient), then for
//   each exponent candidate e tried, the bit-serial divider (one quotient bit
//   per cycle), the gcd steps and a decision, then the private exponent terms
//   before the out_valid cycle; the divider sets most of the time. One item at a
//   time: the next start is taken in the cycle out_valid is high.
//   Reset (rst_n low, synchronous) returns the controller to idle and drops
//   any key in progress; no result is sent for it.
// ----------------------------------------------------------------------------
module rsa_small_key_derivation #(
  parameter int PRIME_BITS = rsakd_pkg::PRIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [PRIME_BITS-1:0]          in_prime_p,
  input  logic [PRIME_BITS-1:0]          in_prime_q,
  output logic                           out_valid,
  output logic [rsakd_pkg::MOD_BITS-1:0] out_modulus,
  output logic [rsakd_pkg::EXP_BITS-1:0] out_public_exp,
  output logic [rsakd_pkg::MOD_BITS-1:0] out_private_exp,
  output logic                           out_failed
);
  import rsakd_pkg::*;

  // Command and status between the sequencer and the arithmetic
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence the multiply, the exponent search (divide then gcd per
  // candidate) and the private exponent accumulation.
  rsakd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Hold factors and intermediate values; results come straight from the
  // datapath registers, which stay put until the next beat is accepted.
  rsakd_dp #(
    .PRIME_BITS (PRIME_BITS)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .stat        (stat),
    .prime_p     (in_prime_p),
    .prime_q     (in_prime_q),
    .modulus     (out_modulus),
    .public_exp  (out_public_exp),
    .private_exp (out_private_exp),
    .failed      (out_failed)
  );

endmodule

[design/rsakd_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsakd_dp
// Datapath: shared multiplier, bit-serial restoring divider, subtractive gcd
// and the incremental private exponent accumulator.
// ----------------------------------------------------------------------------
module rsakd_dp #(
  parameter int PRIME_BITS = rsakd_pkg::PRIME_BITS_DEF
) (
  input  logic                          clk,
  input  rsakd_pkg::dp_cmd_t            cmd,
  output rsakd_pkg::dp_stat_t           stat,
  input  logic [PRIME_BITS-1:0]         prime_p,
  input  logic [PRIME_BITS-1:0]         prime_q,
  output logic [rsakd_pkg::MOD_BITS-1:0] modulus,
  output logic [rsakd_pkg::EXP_BITS-1:0] public_exp,
  output logic [rsakd_pkg::MOD_BITS-1:0] private_exp,
  output logic                          failed
);
  import rsakd_pkg::*;

  localparam int PW = 2 * PRIME_BITS;
  localparam int CW = $clog2(PW);
  localparam int DW = PW + 1;

  logic [PRIME_BITS-1:0] p_r, q_r, pm_r, qm_r;
  logic [PW-1:0]         n_r, phi_r;
  logic [EXP_W-1:0]      e_r;
  logic [PW-1:0]         dvd_r, quo_r;
  logic [EXP_W-1:0]      rem_r;
  logic [CW-1:0]         cnt_r;
  logic [EXP_W-1:0]      gx_r, gy_r;
  logic [EXP_W-1:0]      lowmod_r;
  logic [DW-1:0]         d_r;
  logic                  fail_r;

  logic [PRIME_BITS-1:0] mul_a, mul_b;
  logic [PW-1:0]         mul_y;
  logic [EXP_W:0]        trial;
  logic                  trial_ge;
  logic [EXP_W:0]        acc_sum;
  logic                  acc_carry;
  logic [EXP_W-1:0]      acc_mod;

  // Shared multiplier
  always_comb begin
    mul_a = cmd.mul_phi ? pm_r : p_r;
    mul_b = cmd.mul_phi ? qm_r : q_r;
    mul_y = PW'(mul_a) * PW'(mul_b);
  end

  // Restoring divider: one quotient bit per step
  always_comb begin
    trial    = {rem_r, dvd_r[PW-1]};
    trial_ge = (trial >= {1'b0, e_r});
  end

  // Running numerator residue: remainder plus one on the first term, else residue plus remainder; reduce once
  always_comb begin
    acc_sum   = cmd.d_init ? ({1'b0, rem_r} + (EXP_W+1)'(1))
                           : ({1'b0, lowmod_r} + {1'b0, rem_r});
    acc_carry = (acc_sum >= {1'b0, e_r});
    acc_mod   = acc_carry ? EXP_W'(acc_sum - {1'b0, e_r}) : EXP_W'(acc_sum);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r    <= prime_p;
      q_r    <= prime_q;
      pm_r   <= (prime_p != '0) ? prime_p - PRIME_BITS'(1) : '0;
      qm_r   <= (prime_q != '0) ? prime_q - PRIME_BITS'(1) : '0;
      d_r    <= '0;
      fail_r <= 1'b0;
    end
    if (cmd.mul_n) begin
      n_r <= mul_y;
    end
    if (cmd.mul_phi) begin
      phi_r <= mul_y;
      e_r   <= E_FIRST;
    end
    if (cmd.e_inc) begin
      e_r <= e_r + EXP_W'(1);
    end
    if (cmd.div_init) begin
      dvd_r <= phi_r;
      quo_r <= '0;
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      dvd_r <= {dvd_r[PW-2:0], 1'b0};
      quo_r <= {quo_r[PW-2:0], trial_ge};
      rem_r <= trial_ge ? EXP_W'(trial - {1'b0, e_r}) : EXP_W'(trial);
      cnt_r <= cnt_r + CW'(1);
    end
    if (cmd.gcd_init) begin
      gx_r <= e_r;
      gy_r <= rem_r;
    end
    if (cmd.gcd_step) begin
      if (gx_r >= gy_r) begin
        gx_r <= gx_r - gy_r;
      end else begin
        gx_r <= gy_r;
        gy_r <= gx_r;
      end
    end
    if (cmd.fail_set) begin
      fail_r <= 1'b1;
    end
    if (cmd.d_init) begin
      lowmod_r <= acc_mod;
      d_r      <= DW'(quo_r) + DW'(acc_carry);
    end
    if (cmd.d_step) begin
      lowmod_r <= acc_mod;
      d_r      <= d_r + DW'(quo_r) + DW'(acc_carry);
    end
  end

  assign stat.div_last = (cnt_r == CW'(PW - 1));
  assign stat.gcd_done = (gy_r == '0);
  assign stat.gcd_one  = (gx_r == EXP_W'(1));
  assign stat.e_lt_phi = (PW'(e_r) < phi_r);
  assign stat.d_hit    = (lowmod_r == '0);

  assign modulus     = MOD_BITS'(n_r);
  assign public_exp  = EXP_BITS'(e_r);
  assign private_exp = MOD_BITS'(d_r);
  assign failed      = fail_r;

endmodule

[design/rsakd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsakd_ctrl
// Controller: sequences multiply, exponent search, gcd and private exponent
// accumulation, and raises the result strobe.
// ----------------------------------------------------------------------------
module rsakd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output logic                 out_valid,
  output rsakd_pkg::dp_cmd_t   cmd,
  input  rsakd_pkg::dp_stat_t  stat
);
  import rsakd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_N, S_MUL_PHI, S_DIV_INIT, S_DIV,
    S_GCD_INIT, S_GCD, S_D_INIT, S_D
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL_N;
        end
      end
      S_MUL_N: begin
        cmd.mul_n = 1'b1;
        state_nxt = S_MUL_PHI;
      end
      S_MUL_PHI: begin
        cmd.mul_phi = 1'b1;
        state_nxt   = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_GCD_INIT;
        end
      end
      S_GCD_INIT: begin
        cmd.gcd_init = 1'b1;
        state_nxt    = S_GCD;
      end
      S_GCD: begin
        if (!stat.gcd_done) begin
          cmd.gcd_step = 1'b1;
        end else if (stat.gcd_one) begin
          state_nxt = S_D_INIT;
        end else if (stat.e_lt_phi) begin
          cmd.e_inc = 1'b1;
          state_nxt = S_DIV_INIT;
        end else begin
          cmd.fail_set  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_D_INIT: begin
        cmd.d_init = 1'b1;
        state_nxt  = S_D;
      end
      S_D: begin
        if (stat.d_hit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.d_step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule
